### src/assert_macros.svh
// assertion macros shared by the cache directory rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cache directory assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cache directory assertion failed");

`endif

### src/fwbc_pkg.sv
`timescale 1ns / 1ps
// shared widths, codes and types of the cache directory
package fwbc_pkg;

	localparam int OP_W   = 2;
	localparam int BLK_W  = 31;
	localparam int ACT_W  = 3;
	localparam int SLOT_W = 5;
	localparam int CFG_W  = 6;
	localparam int PTR_W  = 5;

	localparam logic [CFG_W-1:0] SLOTS_RESET = 6'd32;

	typedef enum logic [OP_W-1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2,
		OP_INVAL = 2'd3
	} op_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_HIT   = 3'd0,
		ACT_PLACE = 3'd1,
		ACT_FILL  = 3'd2,
		ACT_WBACK = 3'd3,
		ACT_DONE  = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_VICTIM,
		ST_PLACE,
		ST_FLUSH,
		ST_DONE
	} state_t;

	// per-slot update commands driven by the sequencer
	typedef struct packed {
		logic place;
		logic place_dirty;
		logic mark_dirty;
		logic clean;
		logic wipe;
	} cell_cmd_t;

endpackage

### src/fwbc_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces of the cache directory

interface fwbc_req_if;
	logic                         valid;
	logic                         ready;
	logic [fwbc_pkg::OP_W-1:0]    op;
	logic [fwbc_pkg::BLK_W-1:0]   block_number;

	modport source (output valid, output op, output block_number, input ready);
	modport sink (input valid, input op, input block_number, output ready);
endinterface

interface fwbc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [fwbc_pkg::ACT_W-1:0]   action;
	logic [fwbc_pkg::SLOT_W-1:0]  slot;
	logic [fwbc_pkg::BLK_W-1:0]   result_block;
	logic                         last;

	modport source (output valid, output action, output slot, output result_block,
		output last, input ready);
	modport sink (input valid, input action, input slot, input result_block,
		input last, output ready);
endinterface

### src/fwbc_cell.sv
`timescale 1ns / 1ps
// one directory slot: tag, valid and dirty marks, and its link of the hit chain
module fwbc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [fwbc_pkg::BLK_W-1:0] key,
	input  logic                       active,
	input  logic                       hit_in,
	input  fwbc_pkg::cell_cmd_t        cmd,
	output logic                       hit_out,
	output logic                       first,
	output logic [fwbc_pkg::BLK_W-1:0] tag,
	output logic                       valid,
	output logic                       dirty
);

	logic [fwbc_pkg::BLK_W-1:0] tag_q;
	logic                       valid_q;
	logic                       dirty_q;
	logic                       match;

	// compare and pass the hit on to the next slot up
	assign match   = active & valid_q & (tag_q == key);
	assign first   = match & ~hit_in;
	assign hit_out = hit_in | match;

	assign tag   = tag_q;
	assign valid = valid_q;
	assign dirty = dirty_q;

	// tag storage, written only when the slot is placed
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			tag_q <= key;
		end
	end

	// valid and dirty marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (cmd.wipe) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (cmd.place) begin
			valid_q <= 1'b1;
			dirty_q <= cmd.place_dirty;
		end else if (cmd.mark_dirty) begin
			dirty_q <= 1'b1;
		end else if (cmd.clean) begin
			dirty_q <= 1'b0;
		end
	end

endmodule

### src/fifo_writeback_block_cache_directory_top.sv
`timescale 1ns / 1ps
// top level of the write-back block cache directory
// Directory of a fully associative write-back block cache with oldest-first
// replacement, handling one transaction at a time. Slots form a row of cells
// that compare their tags in parallel and pass a hit mark to their neighbor,
// so the lowest matching slot wins. A flush is paced by the scan, which visits
// one slot per cycle through the shared slot read port, except that it holds on
// a dirty slot while the output register is not free to take its result. Any
// step that loads a result also waits for every cycle in which the output
// register still holds a result that the result side has not taken. A new
// request is taken as soon as the last result of the previous one sits in the
// output register.
`include "assert_macros.svh"

module fifo_writeback_block_cache_directory_top #(
	parameter int NUM_SLOTS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fwbc_req_if.sink                   req,
	fwbc_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [fwbc_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = fwbc_pkg::CFG_W;
	localparam int PTR_W = fwbc_pkg::PTR_W;
	localparam int BLK_W = fwbc_pkg::BLK_W;
	localparam int ACT_W = fwbc_pkg::ACT_W;
	localparam int SLOT_W = fwbc_pkg::SLOT_W;
	localparam logic [CNT_W-1:0] SLOTS_MAX = CNT_W'(NUM_SLOTS);

	fwbc_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] slots_q;
	logic [CNT_W-1:0] n_act;
	fwbc_pkg::op_t    req_op_q;
	logic [BLK_W-1:0] req_blk_q;
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] victim_q;
	logic [CNT_W-1:0] scan_q;

	logic             rsp_valid_q;
	logic [ACT_W-1:0] rsp_act_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic [BLK_W-1:0] rsp_blk_q;
	logic             rsp_last_q;

	logic             acc;
	logic             out_free;
	logic             any_hit;
	logic [CNT_W-1:0] hit_cnt;
	logic [CNT_W-1:0] victim_next;
	logic [CNT_W-1:0] ptr_inc;
	logic [CNT_W-1:0] rd_cnt;
	logic [IDX_W-1:0] rd_idx;
	logic [BLK_W-1:0] rd_tag;
	logic             rd_wb;

	// sequencer outputs
	logic             load;
	logic [ACT_W-1:0] ld_act;
	logic [CNT_W-1:0] ld_cnt;
	logic [BLK_W-1:0] ld_blk;
	logic             ld_last;
	logic             place_en;
	logic             mark_en;
	logic             clean_en;
	logic             wipe_en;
	logic             ptr_upd;
	logic             victim_ld;
	logic             scan_inc;

	// terms used by the checks
	logic             victim_busy;
	logic             done_out;
	logic             done_clean;

	logic [NUM_SLOTS:0]   chain;
	logic [NUM_SLOTS-1:0] first;
	logic [NUM_SLOTS-1:0] active;
	logic [NUM_SLOTS-1:0] valid_vec;
	logic [NUM_SLOTS-1:0] dirty_vec;
	logic [BLK_W-1:0]     tag_arr [NUM_SLOTS];
	fwbc_pkg::cell_cmd_t  cell_cmd [NUM_SLOTS];

	// handshakes
	assign req.ready = (state_q == fwbc_pkg::ST_IDLE);
	assign acc       = req.valid & req.ready;
	assign out_free  = ~rsp_valid_q | rsp.ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= fwbc_pkg::SLOTS_RESET;
		end else if (cfg_we) begin
			slots_q <= cfg_wdata;
		end
	end

	// clamp slot count to 1..NUM_SLOTS
	always_comb begin
		if (slots_q == '0) begin
			n_act = CNT_W'(1);
		end else if (slots_q > SLOTS_MAX) begin
			n_act = SLOTS_MAX;
		end else begin
			n_act = slots_q;
		end
	end

	// row of slot cells
	assign chain[0] = 1'b0;
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		assign active[i] = (CNT_W'(i) < n_act);

		fwbc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (req_blk_q),
			.active  (active[i]),
			.hit_in  (chain[i]),
			.cmd     (cell_cmd[i]),
			.hit_out (chain[i+1]),
			.first   (first[i]),
			.tag     (tag_arr[i]),
			.valid   (valid_vec[i]),
			.dirty   (dirty_vec[i])
		);
	end

	assign any_hit = chain[NUM_SLOTS];

	// encode the lowest matching slot
	always_comb begin
		hit_cnt = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (first[i]) begin
				hit_cnt = hit_cnt | CNT_W'(i);
			end
		end
	end

	// per-slot commands
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			cell_cmd[i].place       = place_en & (victim_q[IDX_W-1:0] == IDX_W'(i));
			cell_cmd[i].place_dirty = (req_op_q == fwbc_pkg::OP_WRITE);
			cell_cmd[i].mark_dirty  = mark_en & first[i];
			cell_cmd[i].clean       = clean_en & (scan_q[IDX_W-1:0] == IDX_W'(i));
			cell_cmd[i].wipe        = wipe_en;
		end
	end

	// shared slot read port: scan slot during flush, victim otherwise
	assign rd_cnt = (state_q == fwbc_pkg::ST_FLUSH) ? scan_q : victim_q;
	assign rd_idx = rd_cnt[IDX_W-1:0];
	assign rd_tag = tag_arr[rd_idx];
	assign rd_wb  = valid_vec[rd_idx] & dirty_vec[rd_idx];

	// victim choice and pointer advance
	assign victim_next = (CNT_W'(ptr_q) >= n_act) ? '0 : CNT_W'(ptr_q);
	assign ptr_inc     = victim_q + CNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fwbc_pkg::ST_IDLE: begin
				if (acc) begin
					unique case (fwbc_pkg::op_t'(req.op))
						fwbc_pkg::OP_READ,
						fwbc_pkg::OP_WRITE: state_d = fwbc_pkg::ST_LOOKUP;
						fwbc_pkg::OP_FLUSH: state_d = fwbc_pkg::ST_FLUSH;
						fwbc_pkg::OP_INVAL: state_d = fwbc_pkg::ST_DONE;
					endcase
				end
			end
			fwbc_pkg::ST_LOOKUP: begin
				if (!any_hit) begin
					state_d = fwbc_pkg::ST_VICTIM;
				end else if (out_free) begin
					state_d = fwbc_pkg::ST_IDLE;
				end
			end
			fwbc_pkg::ST_VICTIM: begin
				if (!rd_wb || out_free) begin
					state_d = fwbc_pkg::ST_PLACE;
				end
			end
			fwbc_pkg::ST_PLACE: begin
				if (out_free) begin
					state_d = fwbc_pkg::ST_IDLE;
				end
			end
			fwbc_pkg::ST_FLUSH: begin
				if (scan_q >= n_act) begin
					state_d = fwbc_pkg::ST_DONE;
				end
			end
			fwbc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = fwbc_pkg::ST_IDLE;
				end
			end
			default: state_d = fwbc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		load      = 1'b0;
		ld_act    = fwbc_pkg::ACT_DONE;
		ld_cnt    = '0;
		ld_blk    = '0;
		ld_last   = 1'b1;
		place_en  = 1'b0;
		mark_en   = 1'b0;
		clean_en  = 1'b0;
		wipe_en   = 1'b0;
		ptr_upd   = 1'b0;
		victim_ld = 1'b0;
		scan_inc  = 1'b0;
		unique case (state_q)
			fwbc_pkg::ST_IDLE: begin
				wipe_en = acc & (fwbc_pkg::op_t'(req.op) == fwbc_pkg::OP_INVAL);
			end
			fwbc_pkg::ST_LOOKUP: begin
				if (!any_hit) begin
					victim_ld = 1'b1;
				end else if (out_free) begin
					load    = 1'b1;
					ld_act  = fwbc_pkg::ACT_HIT;
					ld_cnt  = hit_cnt;
					ld_blk  = req_blk_q;
					mark_en = (req_op_q == fwbc_pkg::OP_WRITE);
				end
			end
			fwbc_pkg::ST_VICTIM: begin
				if (rd_wb && out_free) begin
					load    = 1'b1;
					ld_act  = fwbc_pkg::ACT_WBACK;
					ld_cnt  = victim_q;
					ld_blk  = rd_tag;
					ld_last = 1'b0;
				end
			end
			fwbc_pkg::ST_PLACE: begin
				if (out_free) begin
					load     = 1'b1;
					ld_act   = (req_op_q == fwbc_pkg::OP_WRITE) ?
						fwbc_pkg::ACT_PLACE : fwbc_pkg::ACT_FILL;
					ld_cnt   = victim_q;
					ld_blk   = req_blk_q;
					place_en = 1'b1;
					ptr_upd  = 1'b1;
				end
			end
			fwbc_pkg::ST_FLUSH: begin
				if (scan_q < n_act) begin
					if (!rd_wb) begin
						scan_inc = 1'b1;
					end else if (out_free) begin
						load     = 1'b1;
						ld_act   = fwbc_pkg::ACT_WBACK;
						ld_cnt   = scan_q;
						ld_blk   = rd_tag;
						ld_last  = 1'b0;
						clean_en = 1'b1;
						scan_inc = 1'b1;
					end
				end
			end
			fwbc_pkg::ST_DONE: begin
				load = out_free;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fwbc_pkg::ST_IDLE;
			ptr_q    <= '0;
			victim_q <= '0;
			scan_q   <= '0;
		end else begin
			state_q <= state_d;
			if (wipe_en) begin
				ptr_q <= '0;
			end else if (ptr_upd) begin
				ptr_q <= (ptr_inc >= n_act) ? '0 : ptr_inc[PTR_W-1:0];
			end
			if (victim_ld) begin
				victim_q <= victim_next;
			end
			if (acc) begin
				scan_q <= '0;
			end else if (scan_inc) begin
				scan_q <= scan_q + CNT_W'(1);
			end
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (acc) begin
			req_op_q  <= fwbc_pkg::op_t'(req.op);
			req_blk_q <= req.block_number;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_act_q  <= ld_act;
			rsp_slot_q <= ld_cnt[SLOT_W-1:0];
			rsp_blk_q  <= ld_blk;
			rsp_last_q <= ld_last;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.action       = rsp_act_q;
	assign rsp.slot         = rsp_slot_q;
	assign rsp.result_block = rsp_blk_q;
	assign rsp.last         = rsp_last_q;

	// terms for the checks
	assign victim_busy = (state_q == fwbc_pkg::ST_VICTIM) || (state_q == fwbc_pkg::ST_PLACE);
	assign done_out    = rsp.valid && (rsp.action == fwbc_pkg::ACT_DONE);
	assign done_clean  = (rsp.slot == '0) && (rsp.result_block == '0) && rsp.last;

	// checks
	`ASSERT_IMPL(a_single_first_hit, clk, arst_n, 1'b1, $onehot0(first))
	`ASSERT_IMPL(a_victim_in_range, clk, arst_n, victim_busy, victim_q < n_act)
	`ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, acc, state_q != fwbc_pkg::ST_IDLE)
	`ASSERT_IMPL(a_done_is_clean, clk, arst_n, done_out, done_clean)

endmodule
